>>> sv/fraction_to_decimal_digits_unit_assert.svh
// Assertion macros for the fraction-to-decimal unit.
`ifndef FRACTION_TO_DECIMAL_DIGITS_UNIT_ASSERT_SVH
`define FRACTION_TO_DECIMAL_DIGITS_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define FRDEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frdec: same-cycle check failed");

// Next-cycle implication, checked on clk, off during reset.
`define FRDEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frdec: next-cycle check failed");

`endif

>>> sv/frdec_pkg.sv
// Shared types and constants of the fraction-to-decimal unit.
package frdec_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned LIM_W      = 6;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned LEFT_W     = 5;
  localparam int unsigned PROD_W     = WORD_W + 4;
  localparam int unsigned KCNT_W     = 2;

  localparam logic [LIM_W-1:0]  LIM_RESET = 6'd43;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

  typedef struct packed {
    logic load;
    logic div_step;
    logic skip_shift;
    logic emit_int;
    logic emit_dot;
    logic fdiv_step;
    logic emit_frac;
    logic emit_err;
  } frdec_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic top_zero;
    logic int_one_left;
    logic rem_zero;
    logic lim_zero;
    logic k_done;
    logic frac_last;
    logic out_free;
  } frdec_stat_t;

endpackage

>>> sv/frdec_in_if.sv
// Input channel: one fraction per beat.
interface frdec_in_if;
  import frdec_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] numerator;
  logic [WORD_W-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

>>> sv/frdec_out_if.sv
// Result channel: one ASCII character per beat.
interface frdec_out_if;
  import frdec_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;
  logic              error;

  modport source (output valid, output char_code, output last, output error, input ready);
  modport sink   (input valid, input char_code, input last, input error, output ready);
endinterface

>>> sv/frdec_datapath.sv
// Datapath: restoring divider, double-dabble, fraction digit divider, output register.
module frdec_datapath #(
  parameter int unsigned MAX_FRAC_DIGITS = 43
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [frdec_pkg::WORD_W-1:0]       in_num,
  input  logic [frdec_pkg::WORD_W-1:0]       in_den,
  input  logic                               cfg_we,
  input  logic [frdec_pkg::LIM_W-1:0]        cfg_wdata,
  input  frdec_pkg::frdec_cmd_t              cmd,
  output frdec_pkg::frdec_stat_t             stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [frdec_pkg::CHAR_W-1:0]       out_char,
  output logic                               out_last,
  output logic                               out_error
);
  import frdec_pkg::*;

  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_FRAC_DIGITS);

  function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (r[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = r[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic [PROD_W-1:0] times_ten(input logic [WORD_W-1:0] x);
    return PROD_W'({x, 3'b000}) + PROD_W'({x, 1'b0});
  endfunction

  logic [WORD_W-1:0] num_r, den_r, rem_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [LEFT_W-1:0] left_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [KCNT_W-1:0] kcnt_r;
  logic [PROD_W-1:0] p_r;
  logic [3:0]        dig_r;
  logic [LIM_W-1:0]  fcnt_r;
  logic [LIM_W-1:0]  lim_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r, err_r;

  // integer division step
  logic [WORD_W:0]   trial;
  logic              q_bit;
  logic [BCD_W-1:0]  bcd_adj;
  // fraction digit step
  logic [PROD_W-1:0] den_sh;
  logic              f_bit;
  logic [LIM_W-1:0]  lim_eff;
  logic              out_free;

  assign trial   = {rem_r, num_r[WORD_W-1]};
  assign q_bit   = trial >= {1'b0, den_r};
  assign bcd_adj = dabble_adj(bcd_r);
  assign den_sh  = PROD_W'(den_r) << kcnt_r;
  assign f_bit   = p_r >= den_sh;
  assign lim_eff = (lim_r > MAX_LIM) ? MAX_LIM : lim_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.den_zero     = den_r == '0;
    stat.div_done     = cnt_r == CNT_W'(DIV_STEPS - 1);
    stat.top_zero     = bcd_r[BCD_W-1 -: 4] == 4'd0;
    stat.int_one_left = left_r == LEFT_W'(1);
    stat.rem_zero     = rem_r == '0;
    stat.lim_zero     = lim_eff == '0;
    stat.k_done       = kcnt_r == '0;
    stat.frac_last    = (p_r == '0) || (LIM_W'(fcnt_r + 1'b1) == lim_eff);
    stat.out_free     = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r       <= LIM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lim_r <= cfg_wdata;
      end
      if (cmd.emit_int || cmd.emit_dot || cmd.emit_frac || cmd.emit_err) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r  <= in_num;
      den_r  <= in_den;
      rem_r  <= '0;
      bcd_r  <= '0;
      cnt_r  <= '0;
      left_r <= LEFT_W'(BCD_DIGITS);
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? WORD_W'(trial - {1'b0, den_r}) : trial[WORD_W-1:0];
      num_r <= {num_r[WORD_W-2:0], 1'b0};
      bcd_r <= {bcd_adj[BCD_W-2:0], q_bit};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.skip_shift || cmd.emit_int) begin
      bcd_r  <= {bcd_r[BCD_W-5:0], 4'd0};
      left_r <= left_r - 1'b1;
    end
    if (cmd.emit_dot) begin
      p_r    <= times_ten(rem_r);
      kcnt_r <= '1;
      fcnt_r <= '0;
    end
    if (cmd.fdiv_step) begin
      p_r    <= f_bit ? p_r - den_sh : p_r;
      dig_r  <= {dig_r[2:0], f_bit};
      kcnt_r <= kcnt_r - 1'b1;
    end
    if (cmd.emit_frac) begin
      p_r    <= times_ten(p_r[WORD_W-1:0]);
      kcnt_r <= '1;
      fcnt_r <= fcnt_r + 1'b1;
    end

    if (cmd.emit_int) begin
      char_r <= CHAR_ZERO + CHAR_W'(bcd_r[BCD_W-1 -: 4]);
      last_r <= stat.int_one_left && stat.rem_zero;
      err_r  <= 1'b0;
    end
    if (cmd.emit_dot) begin
      char_r <= CHAR_DOT;
      last_r <= stat.lim_zero;
      err_r  <= 1'b0;
    end
    if (cmd.emit_frac) begin
      char_r <= CHAR_ZERO + CHAR_W'(dig_r);
      last_r <= stat.frac_last;
      err_r  <= 1'b0;
    end
    if (cmd.emit_err) begin
      char_r <= CHAR_NONE;
      last_r <= 1'b1;
      err_r  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;
  assign out_error = err_r;

endmodule

>>> sv/frdec_ctrl.sv
// Controller: sequences division, digit emission and the fraction loop.
module frdec_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   idle,
  input  frdec_pkg::frdec_stat_t stat,
  output frdec_pkg::frdec_cmd_t  cmd
);
  import frdec_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_SKIP  = 8'b0000_0100,
    ST_INT   = 8'b0000_1000,
    ST_DOT   = 8'b0001_0000,
    ST_FDIV  = 8'b0010_0000,
    ST_FEMIT = 8'b0100_0000,
    ST_ERR   = 8'b1000_0000
  } frdec_state_t;

  frdec_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.den_zero) begin
          state_nxt = ST_ERR;
        end else begin
          cmd.div_step = 1'b1;
          if (stat.div_done) begin
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_SKIP: begin
        if (stat.top_zero && !stat.int_one_left) begin
          cmd.skip_shift = 1'b1;
        end else begin
          state_nxt = ST_INT;
        end
      end
      ST_INT: begin
        if (stat.out_free) begin
          cmd.emit_int = 1'b1;
          if (stat.int_one_left) begin
            state_nxt = stat.rem_zero ? ST_IDLE : ST_DOT;
          end
        end
      end
      ST_DOT: begin
        if (stat.out_free) begin
          cmd.emit_dot = 1'b1;
          state_nxt    = stat.lim_zero ? ST_IDLE : ST_FDIV;
        end
      end
      ST_FDIV: begin
        cmd.fdiv_step = 1'b1;
        if (stat.k_done) begin
          state_nxt = ST_FEMIT;
        end
      end
      ST_FEMIT: begin
        if (stat.out_free) begin
          cmd.emit_frac = 1'b1;
          state_nxt     = stat.frac_last ? ST_IDLE : ST_FDIV;
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign idle = state_r == ST_IDLE;

endmodule

>>> sv/fraction_to_decimal_digits_unit.sv
// Fraction to decimal text: numerator/denominator in, one ASCII char per beat out.
//
// in_ch  : valid/ready beat carrying numerator and denominator (64 bits each).
// out_ch : valid/ready beat carrying char_code, last, error. The text is the
//          integer part without leading zeros, then '.' and fraction digits if
//          the remainder is nonzero. last marks the final char of each fraction.
//          A zero denominator gives one beat with error = 1, char_code = 0.
// cfg_we/cfg_wdata: write of frac_digit_limit (reset 43, clamped to
//          MAX_FRAC_DIGITS); write only while the unit is idle.
// Steps: accept the fraction, restoring division (one quotient bit per cycle,
// fed straight into a double-dabble BCD register), dropping the leading zeros,
// one emit per integer digit, the point, then for each fraction digit
// 4 restoring steps on 10*remainder plus the emit.
// One fraction is in flight at a time; in_ch.ready is high only when idle.
// A stalled receiver holds the output register and freezes the controller at
// its next emit; nothing is dropped. Reset (synchronous, rst_n low) returns
// the controller to idle, empties the output register and restores the limit.
module fraction_to_decimal_digits_unit #(
  parameter int unsigned MAX_FRAC_DIGITS = 43
) (
  input  logic                        clk,
  input  logic                        rst_n,
  frdec_in_if.sink                    in_ch,
  frdec_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [frdec_pkg::LIM_W-1:0] cfg_wdata
);
  import frdec_pkg::*;

`include "fraction_to_decimal_digits_unit_assert.svh"

  frdec_cmd_t  cmd;
  frdec_stat_t stat;
  logic        idle;

  // Controller: owns only the sequence, never touches payload.
  frdec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .idle     (idle),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: divider, BCD converter, fraction digit unit, output register.
  frdec_datapath #(
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_num    (in_ch.numerator),
    .in_den    (in_ch.denominator),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_char  (out_ch.char_code),
    .out_last  (out_ch.last),
    .out_error (out_ch.error)
  );

  assign in_ch.ready = idle;

  // Once a fraction is taken, the unit is busy for at least the next cycle.
  `FRDEC_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  // An emit never overwrites a beat the receiver has not taken.
  `FRDEC_ASSERT_NOW(a_emit_slot_free,
    cmd.emit_int || cmd.emit_dot || cmd.emit_frac || cmd.emit_err,
    !out_ch.valid || out_ch.ready)
  // An error beat is always alone: last set and no character.
  `FRDEC_ASSERT_NOW(a_error_beat,
    out_ch.valid && out_ch.error,
    out_ch.last && (out_ch.char_code == CHAR_NONE))

endmodule

>>> test/fraction_text_checker.sv
// Checker for the fraction-to-decimal unit: predicts each fraction's text, compares every char.
`timescale 1ns / 1ps
module fraction_text_checker #(
  parameter int unsigned MAX_FRAC_DIGITS = 43
) (
  input  logic                        clk,
  input  logic                        rst_n,
  frdec_in_if                         frac_mon,
  frdec_out_if                        text_mon,
  input  logic                        cfg_we,
  input  logic [frdec_pkg::LIM_W-1:0] cfg_wdata,
  output int unsigned                 mismatches,
  output int unsigned                 chars_due,
  output int unsigned                 chars_seen,
  output int unsigned                 fractions_seen,
  output int unsigned                 zero_divs
);
  import frdec_pkg::*;

  localparam int unsigned REPORT_MAX = 20;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              error;
  } text_char_t;

  text_char_t       text_due[$];
  logic [LIM_W-1:0] digit_limit = LIM_RESET;
  int unsigned      n_bad = 0;
  int unsigned      n_chars = 0;
  int unsigned      n_fracs = 0;
  int unsigned      n_zero = 0;

  function automatic void push_char(logic [CHAR_W-1:0] code);
    text_due.push_back('{code: code, last: 1'b0, error: 1'b0});
  endfunction

  // Integer part without leading zeros, then '.' and long-division digits.
  function automatic void spell_fraction(logic [WORD_W-1:0] num, logic [WORD_W-1:0] den,
                                         logic [LIM_W-1:0] lim);
    logic [WORD_W-1:0] whole;
    logic [WORD_W-1:0] rem;
    logic [PROD_W-1:0] prod;
    logic [3:0]        digs [BCD_DIGITS];
    int unsigned       nd;
    int unsigned       cap;
    int unsigned       taken;
    text_char_t        tail;
    if (den == '0) begin
      text_due.push_back('{code: CHAR_NONE, last: 1'b1, error: 1'b1});
      return;
    end
    whole = num / den;
    rem   = num % den;
    nd    = 0;
    do begin
      digs[nd] = 4'(whole % 64'd10);
      whole    = whole / 64'd10;
      nd++;
    end while (whole != '0);
    for (int i = int'(nd) - 1; i >= 0; i--) push_char(CHAR_ZERO + CHAR_W'(digs[i]));
    if (rem != '0) begin
      cap = (lim > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : int'(lim);
      push_char(CHAR_DOT);
      taken = 0;
      // 10*rem needs 68 bits; rem < den always holds
      while (taken < cap && rem != '0) begin
        prod = PROD_W'(rem) * PROD_W'(10);
        push_char(CHAR_ZERO + CHAR_W'(prod / PROD_W'(den)));
        rem = WORD_W'(prod % PROD_W'(den));
        taken++;
      end
    end
    tail      = text_due.pop_back();
    tail.last = 1'b1;
    text_due.push_back(tail);
  endfunction

  function automatic void compare_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      n_bad++;
      if (n_bad <= REPORT_MAX)
        $display("%0t: %s mismatch on char %0d: expected 0x%0h, actual 0x%0h",
                 $time, what, n_chars, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    text_char_t want;
    if (!rst_n) begin
      digit_limit = LIM_RESET;
      text_due.delete();
    end else begin
      if (cfg_we) digit_limit = cfg_wdata;
      if (frac_mon.valid && frac_mon.ready) begin
        spell_fraction(frac_mon.numerator, frac_mon.denominator, digit_limit);
        n_fracs++;
        if (frac_mon.denominator == '0) n_zero++;
      end
      if (text_mon.valid && text_mon.ready) begin
        n_chars++;
        if (text_due.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("%0t: unexpected beat, expected none, actual char 0x%0h last %0b error %0b",
                     $time, text_mon.char_code, text_mon.last, text_mon.error);
        end else begin
          want = text_due.pop_front();
          compare_field("char_code", want.code, text_mon.char_code);
          compare_field("last", want.last, text_mon.last);
          compare_field("error", want.error, text_mon.error);
        end
      end
    end
    mismatches     <= n_bad;
    chars_due      <= text_due.size();
    chars_seen     <= n_chars;
    fractions_seen <= n_fracs;
    zero_divs      <= n_zero;
  end

endmodule

>>> test/tb_fraction_to_decimal_digits_unit.sv
// Top of the fraction-to-decimal testbench: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps
module tb_fraction_to_decimal_digits_unit;
  import frdec_pkg::*;

  localparam int unsigned FRAC_CAP         = 43;
  localparam int unsigned RANDOM_PHASES    = 10;
  localparam int unsigned ITEMS_PER_PHASE  = 43;
  // wait after the last fraction; leave room for a stray beat
  localparam int unsigned DRAIN_CYCLES     = 400;
  // long receiver hold, started once after this many result beats
  localparam int unsigned HOLD_CYCLES      = 1500;
  localparam int unsigned HOLD_AFTER_BEATS = 3000;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LIM_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned chars_due;
  int unsigned chars_seen;
  int unsigned fractions_seen;
  int unsigned zero_divs;

  bit hold_done = 1'b0;   // set by the receiver once the long hold starts
  bit steady    = 1'b0;   // sender offers back to back while set

  frdec_in_if  frac_ch ();
  frdec_out_if text_ch ();

  fraction_to_decimal_digits_unit #(
    .MAX_FRAC_DIGITS(FRAC_CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (frac_ch),
    .out_ch   (text_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  fraction_text_checker #(
    .MAX_FRAC_DIGITS(FRAC_CAP)
  ) text_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .frac_mon      (frac_ch),
    .text_mon      (text_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .chars_due     (chars_due),
    .chars_seen    (chars_seen),
    .fractions_seen(fractions_seen),
    .zero_divs     (zero_divs)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random word of random bit width, so short and full-size values both show up.
  function automatic logic [WORD_W-1:0] rand_word();
    int unsigned       w;
    logic [WORD_W-1:0] v;
    w = $urandom_range(1, WORD_W);
    v = {$urandom, $urandom};
    if (w < WORD_W) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  // Offer one fraction and return at the edge it is taken. valid stays high, so a
  // back-to-back offer never lowers and raises it in the same step.
  task automatic offer_fraction(input logic [WORD_W-1:0] num, input logic [WORD_W-1:0] den);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      frac_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frac_ch.valid       <= 1'b1;
    frac_ch.numerator   <= num;
    frac_ch.denominator <= den;
    do @(posedge clk); while (!frac_ch.ready);
  endtask

  // Stop offering and wait until every predicted char has come out. Each
  // fraction ends on a beat with last set, so the unit is idle afterwards.
  task automatic settle();
    frac_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_due != 0);
  endtask

  // Digit limit write; only called with the unit idle.
  task automatic set_limit(input logic [LIM_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: random stalls, calm stretches with ready held high, and one long
  // hold while the sender keeps offering, so the unit backs up to its input.
  initial begin : result_sink
    int unsigned stall;
    int unsigned calm;
    int unsigned beats;
    bit          go;
    stall = 0;
    calm  = 0;
    beats = 0;
    text_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && text_ch.valid && text_ch.ready) beats++;
      if (!rst_n) begin
        go = 1'b0;
      end else if (stall != 0) begin
        stall--;
        go = 1'b0;
      end else if (!hold_done && beats >= HOLD_AFTER_BEATS) begin
        hold_done = 1'b1;
        stall     = HOLD_CYCLES - 1;
        go        = 1'b0;
      end else if (calm != 0) begin
        calm--;
        go = 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        calm = $urandom_range(100, 400);
        go   = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = idle_len();
        go    = (stall == 0);
        if (stall != 0) stall--;
      end else begin
        go = 1'b1;
      end
      text_ch.ready <= go;
    end
  end

  // Hard stop in case the unit hangs; far beyond the slowest legal run.
  initial begin : watchdog
    #(100_000_000);
    $display("Timeout with %0d chars still expected", chars_due);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
    logic [LIM_W-1:0]  lim;
    int unsigned       roll;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    frac_ch.valid       <= 1'b0;
    frac_ch.numerator   <= '0;
    frac_ch.denominator <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, limit still at its reset value ---
    offer_fraction(64'd0, 64'd1);          // zero integer part, no point
    offer_fraction(64'd1, 64'd0);          // zero divisor
    offer_fraction(64'd0, 64'd0);
    offer_fraction(ALL_ONES, 64'd0);
    offer_fraction(ALL_ONES, 64'd1);       // 20-digit integer part
    offer_fraction(ALL_ONES, ALL_ONES);    // exactly one
    offer_fraction(64'd1, ALL_ONES);       // tiny fraction, hits the digit cap
    offer_fraction(ALL_ONES - 64'd1, ALL_ONES);  // 10*rem overflows 64 bits
    offer_fraction(64'd1, 64'd3);          // repeating, cut at the cap
    offer_fraction(64'd1, 64'd2);          // terminates early
    offer_fraction(64'd22, 64'd7);
    offer_fraction(64'd10, 64'd1);         // trailing zero digit
    offer_fraction(64'd1, 64'd8);
    offer_fraction(64'd12345678901234567890, 64'd1);
    offer_fraction(64'd0, ALL_ONES);
    offer_fraction(ALL_ONES, 64'd2);       // long integer and ".5"
    offer_fraction(64'd1, TOP_BIT);        // 63 decimals, truncated
    settle();

    // limit of zero: a nonzero remainder still gives a trailing point
    set_limit(6'd0);
    offer_fraction(64'd1, 64'd3);
    offer_fraction(64'd5, 64'd1);
    offer_fraction(64'd7, 64'd2);
    offer_fraction(64'd0, 64'd0);
    settle();

    // limit above the cap acts as the cap
    set_limit(6'd63);
    offer_fraction(64'd1, 64'd7);
    offer_fraction(ALL_ONES, TOP_BIT);
    settle();

    set_limit(6'd1);
    offer_fraction(64'd2, 64'd3);
    offer_fraction(64'd1, 64'd4);
    settle();

    // --- random phases, each under its own limit ---
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       lim = 6'd63;
        1:       lim = 6'd0;
        2:       lim = 6'd43;
        3:       lim = 6'd44;
        4:       lim = 6'd1;
        default: lim = LIM_W'($urandom_range(0, 63));
      endcase
      set_limit(lim);
      steady = (p % 3 == 2);
      repeat (ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        num  = rand_word();
        den  = rand_word();
        if (den == '0) den = 64'd1;
        if (roll < 5) begin
          den = '0;                                      // error beat
        end else if (roll < 30) begin
          num = num % den;                               // pure fraction, long tail
        end else if (roll < 45) begin
          den = 64'($urandom_range(1, 16));              // long integer part
        end else if (roll < 58) begin
          den = 64'd1 << $urandom_range(0, 63);          // terminating in binary
        end else if (roll < 68) begin
          den = 64'd1;                                   // power of ten
          repeat ($urandom_range(0, 19)) den = den * 64'd10;
        end else if (roll < 78) begin
          num = den * 64'($urandom_range(0, 9)) + 64'($urandom_range(0, 2));
        end else if (roll < 86) begin
          num = ALL_ONES - 64'($urandom_range(0, 3));    // near the top of the range
          den = ALL_ONES - 64'($urandom_range(0, 3) * 2);
        end
        offer_fraction(num, den);
      end
      settle();
    end

    steady = 1'b0;
    // watch for stray beats after the last expected char
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d fractions (%0d with a zero divisor), %0d chars checked",
             fractions_seen, zero_divs, chars_seen);
    $display("Digit limits 0, 1, 43, 44, 63 and random; long receiver hold %s",
             hold_done ? "applied" : "not reached");
    if (mismatches == 0 && chars_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
